### rtl/core/sarc_pkg.sv
// sarc_pkg: shared types and constants of the swap slot reference count allocator
// no dependencies; used by every file under rtl/core
package sarc_pkg;

    localparam int CountW = 16;
    localparam int FieldW = 13;
    localparam logic [CountW-1:0] CountMax = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_ENABLED    = 1'b0;
    localparam logic CFG_SLOT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_TAKE  = 2'd1,
        MODE_DROP  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD         = 3'd1,
        STAT_REF_FREE    = 3'd2,
        STAT_DOUBLE_FREE = 3'd3,
        STAT_FULL        = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_INC_SAT,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        logic in_zero;
        logic res_zero;
    } t_alu_flags;

endpackage

### rtl/core/sarc_table.sv
// sarc_table: reference count memory, one write port and one registered read port
// depends on sarc_pkg for the count width
module sarc_table #(
    parameter int AddrW = 13,
    parameter int Depth = 4097
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AddrW-1:0]           i_waddr,
    input  logic [sarc_pkg::CountW-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AddrW-1:0]           i_raddr,
    output logic [sarc_pkg::CountW-1:0] o_rdata
);

    logic [sarc_pkg::CountW-1:0] r_mem [Depth];
    logic [sarc_pkg::CountW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sarc_alu.sv
// sarc_alu: shared count unit, saturating increment, decrement and zero detect
// depends on sarc_pkg for the op code and flag types
module sarc_alu (
    input  sarc_pkg::t_alu_op           i_op,
    input  logic [sarc_pkg::CountW-1:0] i_count,
    output logic [sarc_pkg::CountW-1:0] o_result,
    output sarc_pkg::t_alu_flags        o_flags
);

    logic [sarc_pkg::CountW-1:0] w_res;

    // one add unit, operand chosen by the op
    always_comb begin
        unique case (i_op)
            sarc_pkg::ALU_INC_SAT: begin
                w_res = (i_count == sarc_pkg::CountMax) ? i_count : i_count + 1'b1;
            end
            sarc_pkg::ALU_DEC: begin
                w_res = i_count - 1'b1;
            end
            default: begin
                w_res = i_count;
            end
        endcase
    end

    assign o_result         = w_res;
    assign o_flags.in_zero  = (i_count == '0);
    assign o_flags.res_zero = (w_res == '0);

endmodule

### rtl/core/swap_slot_refcount_allocator.sv
// swap_slot_refcount_allocator: top level, sequencer around the count memory and unit
// depends on sarc_pkg, sarc_table and sarc_alu
//
// A request is taken when start is high and busy is low; its one result appears for
// exactly one cycle with o_valid and cannot be held off. A disabled request or a bad
// slot number answers in the next cycle and the block is ready again at once. Take
// and drop read the count memory and write it back, query only reads it; each passes
// through a read state and an execute state, as the memory read is registered. Allocate
// scans the memory one slot per cycle from the next-fit hint, wrapping past the last
// slot and looking at no more slots than the effective slot count. After reset a
// clearing pass writes zero to every entry with busy high; configuration writes are
// taken during that pass.
module swap_slot_refcount_allocator #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_slot,
    output logic        o_valid,
    output logic [12:0] o_granted_slot,
    output logic [15:0] o_ref_count,
    output logic [2:0]  o_status,
    output logic [12:0] o_used_slots
);

    localparam int IW = $clog2(MAX_SLOTS + 1);
    localparam int EW = ((IW > sarc_pkg::FieldW) ? IW : sarc_pkg::FieldW) + 1;
    localparam int CW = sarc_pkg::CountW;
    localparam int FW = sarc_pkg::FieldW;

    sarc_pkg::t_state  r_state, n_state;
    logic              r_enabled;
    logic [FW-1:0]     r_slot_count;
    logic [IW-1:0]     r_hint, n_hint;
    logic [IW-1:0]     r_used, n_used;
    logic [IW-1:0]     r_ptr, n_ptr;
    logic [EW-1:0]     r_left, n_left;
    logic              r_chk_valid, n_chk_valid;
    logic [IW-1:0]     r_chk_addr, n_chk_addr;
    logic [IW-1:0]     r_clr, n_clr;
    sarc_pkg::t_mode   r_mode, n_mode;
    logic [IW-1:0]     r_addr, n_addr;

    logic              r_out_valid, n_out_valid;
    logic [FW-1:0]     r_out_granted, n_out_granted;
    logic [CW-1:0]     r_out_count, n_out_count;
    sarc_pkg::t_status r_out_status, n_out_status;
    logic [FW-1:0]     r_out_used, n_out_used;

    logic              w_we, w_re;
    logic [IW-1:0]     w_waddr, w_raddr;
    logic [CW-1:0]     w_wdata, w_rdata, w_alu_res;
    sarc_pkg::t_alu_op    w_alu_op;
    sarc_pkg::t_alu_flags w_flags;
    logic [EW-1:0]     w_n, w_start_hint, w_next_hint;

    sarc_table #(
        .AddrW (IW),
        .Depth (MAX_SLOTS + 1)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sarc_alu u_alu (
        .i_op     (w_alu_op),
        .i_count  (w_rdata),
        .o_result (w_alu_res),
        .o_flags  (w_flags)
    );

    // effective slot count, capped at the table size
    assign w_n = (EW'(r_slot_count) > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : EW'(r_slot_count);

    // normalized start of the search and hint past a found slot
    assign w_start_hint = (r_hint == '0 || EW'(r_hint) > w_n) ? EW'(1) : EW'(r_hint);
    assign w_next_hint  = EW'(r_chk_addr) + EW'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_slot_count <= FW'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sarc_pkg::CFG_ENABLED:    r_enabled    <= i_cfg_wdata[0];
                sarc_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_wdata;
                default:                  r_enabled    <= r_enabled;
            endcase
        end
    end

    // next state, memory control and result
    always_comb begin
        n_state       = r_state;
        n_hint        = r_hint;
        n_used        = r_used;
        n_ptr         = r_ptr;
        n_left        = r_left;
        n_chk_valid   = 1'b0;
        n_chk_addr    = r_chk_addr;
        n_clr         = r_clr;
        n_mode        = r_mode;
        n_addr        = r_addr;
        n_out_valid   = 1'b0;
        n_out_granted = '0;
        n_out_count   = '0;
        n_out_status  = sarc_pkg::STAT_OK;
        w_we          = 1'b0;
        w_waddr       = r_addr;
        w_wdata       = '0;
        w_re          = 1'b0;
        w_raddr       = r_addr;
        w_alu_op      = sarc_pkg::ALU_PASS;

        unique case (r_state)
            sarc_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == IW'(MAX_SLOTS)) begin
                    n_state = sarc_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            sarc_pkg::ST_IDLE: begin
                if (start) begin
                    if (!r_enabled) begin
                        n_out_valid  = 1'b1;
                        n_out_status = sarc_pkg::STAT_BAD;
                    end else if (sarc_pkg::t_mode'(i_mode) == sarc_pkg::MODE_ALLOC) begin
                        n_hint  = IW'(w_start_hint);
                        n_ptr   = IW'(w_start_hint);
                        n_left  = w_n;
                        n_state = sarc_pkg::ST_SCAN;
                    end else if (i_slot == '0 || EW'(i_slot) > w_n) begin
                        n_out_valid  = 1'b1;
                        n_out_status = sarc_pkg::STAT_BAD;
                    end else begin
                        n_addr  = IW'(i_slot);
                        n_mode  = sarc_pkg::t_mode'(i_mode);
                        n_state = sarc_pkg::ST_READ;
                    end
                end
            end
            sarc_pkg::ST_READ: begin
                w_re    = 1'b1;
                n_state = sarc_pkg::ST_EXEC;
            end
            sarc_pkg::ST_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = sarc_pkg::ST_IDLE;
                case (r_mode)
                    sarc_pkg::MODE_TAKE: begin
                        w_alu_op = sarc_pkg::ALU_INC_SAT;
                        if (w_flags.in_zero) begin
                            n_out_status = sarc_pkg::STAT_REF_FREE;
                        end else begin
                            w_we        = 1'b1;
                            w_wdata     = w_alu_res;
                            n_out_count = w_alu_res;
                        end
                    end
                    sarc_pkg::MODE_DROP: begin
                        w_alu_op = sarc_pkg::ALU_DEC;
                        if (w_flags.in_zero) begin
                            n_out_status = sarc_pkg::STAT_DOUBLE_FREE;
                        end else begin
                            w_we        = 1'b1;
                            w_wdata     = w_alu_res;
                            n_out_count = w_alu_res;
                            if (w_flags.res_zero) begin
                                n_used = r_used - 1'b1;
                            end
                        end
                    end
                    sarc_pkg::MODE_QUERY: begin
                        n_out_count = w_rdata;
                    end
                    default: begin
                        n_out_status = sarc_pkg::STAT_BAD;
                    end
                endcase
            end
            sarc_pkg::ST_SCAN: begin
                if (r_chk_valid && w_flags.in_zero) begin
                    // free slot found in the cycle after its read
                    w_we          = 1'b1;
                    w_waddr       = r_chk_addr;
                    w_wdata       = CW'(1);
                    n_used        = r_used + 1'b1;
                    n_hint        = (w_next_hint > w_n) ? IW'(1) : IW'(w_next_hint);
                    n_out_valid   = 1'b1;
                    n_out_granted = FW'(r_chk_addr);
                    n_out_count   = CW'(1);
                    n_state       = sarc_pkg::ST_IDLE;
                end else if (r_left == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = sarc_pkg::STAT_FULL;
                    n_state      = sarc_pkg::ST_IDLE;
                end else begin
                    // read the next slot, wrap past the last one
                    w_re        = 1'b1;
                    w_raddr     = r_ptr;
                    n_chk_valid = 1'b1;
                    n_chk_addr  = r_ptr;
                    n_ptr       = (EW'(r_ptr) == w_n) ? IW'(1) : r_ptr + 1'b1;
                    n_left      = r_left - 1'b1;
                end
            end
            default: begin
                n_state = sarc_pkg::ST_IDLE;
            end
        endcase

        n_out_used = FW'(n_used);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sarc_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_hint      <= IW'(1);
            r_used      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_used      <= n_used;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_left        <= n_left;
        r_chk_addr    <= n_chk_addr;
        r_mode        <= n_mode;
        r_addr        <= n_addr;
        r_out_granted <= n_out_granted;
        r_out_count   <= n_out_count;
        r_out_status  <= n_out_status;
        r_out_used    <= n_out_used;
    end

    assign busy           = (r_state != sarc_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_granted_slot = r_out_granted;
    assign o_ref_count    = r_out_count;
    assign o_status       = r_out_status;
    assign o_used_slots   = r_out_used;

endmodule

### rtl/core/sarc_checker.sv
// sarc_checker: port level checks of the allocator results over time
// depends on sarc_pkg for status codes; bound to swap_slot_refcount_allocator
module sarc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [12:0] o_granted_slot,
    input logic [15:0] o_ref_count,
    input logic [2:0]  o_status,
    input logic [12:0] o_used_slots
);

    // an accepted transaction either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction neither answered nor busy");

    // a result is shown only once the block is ready again
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // an error result carries no count and no grant
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != sarc_pkg::STAT_OK) |-> (o_ref_count == '0 && o_granted_slot == '0))
        else $error("error result with count or grant");

    // a grant always starts at one reference and counts as used
    a_grant_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted_slot != '0) |->
            (o_status == sarc_pkg::STAT_OK && o_ref_count == 16'd1 && o_used_slots != '0))
        else $error("grant with wrong count or status");

endmodule

bind swap_slot_refcount_allocator sarc_checker u_sarc_checker (.*);

### tb/swap_slot_refcount_allocator_checker.sv
// swap_slot_refcount_allocator_checker: watches the register port, the request and the reply
// channels, keeps its own copy of the count table and compares every reply; needs sarc_pkg
`timescale 1ns / 1ps

module swap_slot_refcount_allocator_checker
    import sarc_pkg::*;
#(
    parameter int MAX_SLOTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_slot,
    input  logic        i_valid,
    input  logic [12:0] i_granted_slot,
    input  logic [15:0] i_ref_count,
    input  logic [2:0]  i_status,
    input  logic [12:0] i_used_slots,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [12:0] granted;
        logic [15:0] count;
        t_status     status;
        logic [12:0] used;
    } t_reply;

    // mirror of the allocator state and registers
    logic [15:0] slot_refs [0:MAX_SLOTS];
    int          next_fit;
    int          live_total;
    logic        cfg_enabled;
    logic [12:0] cfg_slot_count;

    t_reply owed_replies [$];
    int     mismatch_count;

    function automatic void clear_mirror();
        for (int k = 0; k <= MAX_SLOTS; k++) slot_refs[k] = '0;
        next_fit       = 1;
        live_total     = 0;
        cfg_enabled    = 1'b0;
        cfg_slot_count = 13'd4096;
        owed_replies.delete();
    endfunction

    // apply one request to the mirror and return the reply it must produce
    function automatic t_reply serve_request(t_mode m, logic [12:0] s);
        int     lim;
        int     h;
        int     got;
        int     c;
        t_reply r;
        lim = (cfg_slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slot_count);
        r.granted = '0;
        r.count   = '0;
        r.status  = STAT_OK;
        if (!cfg_enabled) begin
            r.status = STAT_BAD;
        end else if (m == MODE_ALLOC) begin
            h = next_fit;
            if (h == 0 || h > lim) h = 1;
            got = 0;
            // next fit: from the hint to the end, then wrap to slot 1
            for (int k = h; k <= lim && got == 0; k++)
                if (slot_refs[k] == '0) got = k;
            for (int k = 1; k < h && got == 0; k++)
                if (slot_refs[k] == '0) got = k;
            if (got != 0) begin
                slot_refs[got] = 16'd1;
                live_total++;
                h = got + 1;
                r.granted = got[12:0];
                r.count = 16'd1;
            end else begin
                r.status = STAT_FULL;
            end
            if (h > lim) h = 1;
            next_fit = h;
        end else if (s == '0 || int'(s) > lim) begin
            r.status = STAT_BAD;
        end else begin
            c = slot_refs[s];
            case (m)
                MODE_TAKE: begin
                    if (c == 0) begin
                        r.status = STAT_REF_FREE;
                    end else begin
                        if (c < int'(CountMax)) c++;
                        slot_refs[s] = c[15:0];
                        r.count = c[15:0];
                    end
                end
                MODE_DROP: begin
                    if (c == 0) begin
                        r.status = STAT_DOUBLE_FREE;
                    end else begin
                        c--;
                        slot_refs[s] = c[15:0];
                        if (c == 0) live_total--;
                        r.count = c[15:0];
                    end
                end
                default: begin
                    r.count = c[15:0];
                end
            endcase
        end
        r.used = live_total[12:0];
        return r;
    endfunction

    // compare one delivered reply against the oldest prediction
    function automatic void check_reply();
        t_reply e;
        if (owed_replies.size() == 0) begin
            $error("reply transaction with nothing predicted: granted_slot %0d status %0d",
                   i_granted_slot, i_status);
            mismatch_count++;
        end else begin
            e = owed_replies.pop_front();
            if (i_granted_slot !== e.granted) begin
                $error("granted_slot: expected %0d, actual %0d", e.granted, i_granted_slot);
                mismatch_count++;
            end
            if (i_ref_count !== e.count) begin
                $error("ref_count: expected %0d, actual %0d", e.count, i_ref_count);
                mismatch_count++;
            end
            if (i_status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, i_status);
                mismatch_count++;
            end
            if (i_used_slots !== e.used) begin
                $error("used_slots: expected %0d, actual %0d", e.used, i_used_slots);
                mismatch_count++;
            end
        end
    endfunction

    // reply first, then register writes, then the newly accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
            mismatch_count = 0;
        end else begin
            if (i_valid) check_reply();
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_ENABLED) cfg_enabled = i_cfg_wdata[0];
                else cfg_slot_count = i_cfg_wdata;
            end
            if (i_start && !i_busy)
                owed_replies.push_back(serve_request(t_mode'(i_mode), i_slot));
        end
        o_fail_count <= mismatch_count;
        o_pending    <= owed_replies.size();
    end

endmodule

### tb/swap_slot_refcount_allocator_test.sv
// swap_slot_refcount_allocator_test: clock, reset and request stimulus for the allocator
// depends on sarc_pkg, the allocator RTL and swap_slot_refcount_allocator_checker
`timescale 1ns / 1ps

module swap_slot_refcount_allocator_test;
    import sarc_pkg::*;

    localparam int MAX_SLOTS    = 4096;
    localparam int LIMIT_CYCLES = 20_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_addr  = 1'b0;
    logic [12:0] i_cfg_wdata = '0;
    logic        start       = 1'b0;
    logic [1:0]  i_mode      = '0;
    logic [12:0] i_slot      = '0;
    logic        busy;
    logic        o_valid;
    logic [12:0] o_granted_slot;
    logic [15:0] o_ref_count;
    logic [2:0]  o_status;
    logic [12:0] o_used_slots;

    int          fail_count;
    int          owed;
    int          cycle_count = 0;
    bit          allow_gaps  = 1'b1;
    logic [12:0] granted_pool [$];

    swap_slot_refcount_allocator #(
        .MAX_SLOTS(MAX_SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .o_valid       (o_valid),
        .o_granted_slot(o_granted_slot),
        .o_ref_count   (o_ref_count),
        .o_status      (o_status),
        .o_used_slots  (o_used_slots)
    );

    swap_slot_refcount_allocator_checker #(
        .MAX_SLOTS(MAX_SLOTS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .i_valid       (o_valid),
        .i_granted_slot(o_granted_slot),
        .i_ref_count   (o_ref_count),
        .i_status      (o_status),
        .i_used_slots  (o_used_slots),
        .o_fail_count  (fail_count),
        .o_pending     (owed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // remember recently granted slots so take, drop and query often hit live slots
    always @(negedge i_clk) begin
        if (o_valid && o_granted_slot != '0) begin
            granted_pool.push_back(o_granted_slot);
            if (granted_pool.size() > 32) void'(granted_pool.pop_front());
        end
    end

    task automatic write_reg(input logic addr, input logic [12:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one request transaction, with an optional idle burst in front
    task automatic send_request(input t_mode m, input logic [12:0] s);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_mode <= m;
        i_slot <= s;
        do @(posedge i_clk); while (busy);
    endtask

    // stop issuing and wait until every reply has come back
    task automatic settle_down();
        start <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [12:0] pick_slot(int lim);
        int r;
        int top_slot;
        r = $urandom_range(0, 19);
        top_slot = (lim == 0) ? 1 : lim;
        if (r == 0) return 13'd0;
        if (r == 1) return 13'($urandom_range(0, 8191));
        if (r == 2) return 13'(lim + 1);
        if (r < 13 && granted_pool.size() > 0)
            return granted_pool[$urandom_range(0, granted_pool.size() - 1)];
        return 13'($urandom_range(1, top_slot));
    endfunction

    task automatic send_random(input int lim);
        t_mode m;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 35) m = MODE_ALLOC;
        else if (r < 60) m = MODE_TAKE;
        else if (r < 85) m = MODE_DROP;
        else m = MODE_QUERY;
        send_request(m, pick_slot(lim));
    endtask

    task automatic run_phase(input logic en, input logic [12:0] cnt, input int n,
                             input bit gaps);
        int lim;
        lim = (cnt > MAX_SLOTS) ? MAX_SLOTS : int'(cnt);
        settle_down();
        write_reg(CFG_ENABLED, {12'd0, en});
        write_reg(CFG_SLOT_COUNT, cnt);
        allow_gaps = gaps;
        repeat (n) send_random(lim);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // refused while the area is not enabled
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_QUERY, 13'd1);

        // fill a three slot table, then run one slot through its life
        settle_down();
        write_reg(CFG_ENABLED, 13'd1);
        write_reg(CFG_SLOT_COUNT, 13'd3);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_ALLOC, 13'h1FFF);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_TAKE, 13'd2);
        send_request(MODE_DROP, 13'd2);
        send_request(MODE_DROP, 13'd2);
        send_request(MODE_DROP, 13'd2);
        send_request(MODE_TAKE, 13'd2);
        send_request(MODE_QUERY, 13'd2);
        send_request(MODE_QUERY, 13'd3);
        send_request(MODE_TAKE, 13'd0);
        send_request(MODE_QUERY, 13'd4);
        send_request(MODE_DROP, 13'h1FFF);
        send_request(MODE_ALLOC, 13'd0);

        // oversized slot count is capped at the table size
        settle_down();
        write_reg(CFG_SLOT_COUNT, 13'h1FFF);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_TAKE, 13'd4096);
        send_request(MODE_QUERY, 13'd4096);

        // shrunk count leaves the hint stale and the table full
        settle_down();
        write_reg(CFG_SLOT_COUNT, 13'd2);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_QUERY, 13'd3);

        // zero slots: nothing valid at all
        settle_down();
        write_reg(CFG_SLOT_COUNT, 13'd0);
        send_request(MODE_ALLOC, 13'd0);
        send_request(MODE_QUERY, 13'd1);

        // reference updates on slot 1 once the table is back
        settle_down();
        write_reg(CFG_SLOT_COUNT, 13'd2);
        allow_gaps = 1'b0;
        send_request(MODE_TAKE, 13'd1);
        send_request(MODE_QUERY, 13'd1);
        send_request(MODE_DROP, 13'd1);

        // random traffic over several table sizes
        run_phase(1'b1, 13'd16, 140, 1'b1);
        run_phase(1'b1, 13'd1, 140, 1'b1);
        run_phase(1'b1, 13'd40, 140, 1'b1);
        run_phase(1'b0, 13'd16, 40, 1'b1);
        run_phase(1'b1, 13'd4096, 140, 1'b1);
        run_phase(1'b1, 13'd5, 140, 1'b1);
        run_phase(1'b1, 13'h1FFF, 140, 1'b1);
        run_phase(1'b1, 13'd64, 140, 1'b0);

        settle_down();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sarc_pkg.sv
rtl/core/sarc_table.sv
rtl/core/sarc_alu.sv
rtl/core/swap_slot_refcount_allocator.sv
rtl/core/sarc_checker.sv
tb/swap_slot_refcount_allocator_checker.sv
tb/swap_slot_refcount_allocator_test.sv
